// ===== hdl/fcdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter with circular delay line - shared definitions
// Word widths, mode codes and the control bundle of the MAC unit.
// ----------------------------------------------------------------------------
package fcdu_pkg;

  localparam int unsigned DefaultTaps = 64;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned FRAC_W   = 15;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// ===== hdl/fcdu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcdu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fcdu_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered 16x16 signed product followed by a wide accumulator.
// ----------------------------------------------------------------------------
module fcdu_mac #(
  parameter int unsigned ACC_W = 38
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fcdu_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fcdu_pkg::SAMPLE_W-1:0] coef_i,
  input  logic signed [fcdu_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [ACC_W-1:0]              acc_o,
  output logic                                 busy_o
);
  import fcdu_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

// ===== hdl/fir_filter_circular_delay_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter with circular delay line
// Direct-form FIR, Q1.15 in and out, one shared MAC stepped over the taps.
// ----------------------------------------------------------------------------
// Filter word: in_ready_o low after accept while the MAC steps over the taps,
//   then through drain, round and saturate; result valid at the same point;
//   next filter word accepted only then, later while an output word waits.
// Load and unused-mode words: in_ready_o stays high; clear: delay line zeroed.
// After reset both RAMs are swept to zero; in_ready_o is
//   low until the sweep is done.
// ----------------------------------------------------------------------------
module fir_filter_circular_delay_unit #(
  parameter int unsigned TAPS = fcdu_pkg::DefaultTaps
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [fcdu_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [fcdu_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [fcdu_pkg::IDX_W-1:0]           coef_index_i,
  input  logic signed [fcdu_pkg::SAMPLE_W-1:0] coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fcdu_pkg::SAMPLE_W-1:0] filtered_o,
  output logic                                 saturated_o
);
  import fcdu_pkg::*;

  localparam int unsigned AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned ACC_W = PROD_W + AW;
  localparam int unsigned RND_W = ACC_W + 1 - FRAC_W;
  localparam logic [AW-1:0]    LastIdx = AW'(TAPS - 1);
  localparam logic [ACC_W:0]   Half    = (ACC_W + 1)'(1) << (FRAC_W - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RUN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_ROUND = 6'b010000,
    S_SAT   = 6'b100000
  } state_e;

  state_e state_d, state_q;

  logic [AW-1:0] idx_q;
  logic [AW-1:0] pos_q;
  logic [AW-1:0] rp_q;
  logic          clr_coef_q;
  logic          rv_q;

  logic                      accept;
  logic                      is_filter;
  logic                      is_load;
  logic                      is_clear;
  logic                      idx_ok;
  logic                      out_load;

  logic                      dl_we;
  logic [AW-1:0]             dl_waddr;
  logic [SAMPLE_W-1:0]       dl_wdata;
  logic [SAMPLE_W-1:0]       dl_rdata;
  logic                      cf_we;
  logic [AW-1:0]             cf_waddr;
  logic [SAMPLE_W-1:0]       cf_wdata;
  logic [SAMPLE_W-1:0]       cf_rdata;

  mac_ctrl_t                 mac_ctrl;
  logic signed [ACC_W-1:0]   acc;
  logic                      mac_busy;
  logic [ACC_W:0]            biased;
  logic [RND_W-1:0]          rnd_q;
  logic                      sat_hi;
  logic                      sat_lo;

  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                      saturated_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_filter  = (mode_i == MODE_FILTER);
  assign is_load    = (mode_i == MODE_LOAD);
  assign is_clear   = (mode_i == MODE_CLEAR);
  assign idx_ok     = (32'(coef_index_i) < 32'(TAPS));

  // RAM ports
  always_comb begin
    if (state_q == S_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = idx_q;
      dl_wdata = '0;
      cf_we    = clr_coef_q;
      cf_waddr = idx_q;
      cf_wdata = '0;
    end else begin
      dl_we    = accept && is_filter;
      dl_waddr = pos_q;
      dl_wdata = sample_i;
      cf_we    = accept && is_load && idx_ok;
      cf_waddr = AW'(coef_index_i);
      cf_wdata = coef_value_i;
    end
  end

  fcdu_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS),
    .AW    (AW)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (rp_q),
    .rdata_o (dl_rdata)
  );

  fcdu_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS),
    .AW    (AW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .raddr_i (idx_q),
    .rdata_o (cf_rdata)
  );

  assign mac_ctrl.clear = accept && is_filter;
  assign mac_ctrl.valid = rv_q;

  fcdu_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (cf_rdata),
    .sample_i (dl_rdata),
    .acc_o    (acc),
    .busy_o   (mac_busy)
  );

  assign biased   = {acc[ACC_W-1], acc} + Half;
  assign sat_hi   = !rnd_q[RND_W-1] && (|rnd_q[RND_W-2:FRAC_W]);
  assign sat_lo   = rnd_q[RND_W-1] && !(&rnd_q[RND_W-2:FRAC_W]);
  assign out_load = (state_q == S_SAT) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (idx_q == LastIdx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && is_filter) begin
          state_d = S_RUN;
        end else if (accept && is_clear) begin
          state_d = S_CLEAR;
        end
      end
      S_RUN: begin
        if (idx_q == LastIdx) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rv_q && !mac_busy) state_d = S_ROUND;
      end
      S_ROUND: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      pos_q      <= '0;
      rp_q       <= '0;
      clr_coef_q <= 1'b1;
      rv_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == S_RUN);
      unique case (state_q)
        S_CLEAR: begin
          if (idx_q == LastIdx) begin
            idx_q      <= '0;
            clr_coef_q <= 1'b0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && is_filter) begin
            idx_q <= '0;
            rp_q  <= pos_q;
            pos_q <= (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
          end else if (accept && is_clear) begin
            idx_q <= '0;
            pos_q <= '0;
          end
        end
        S_RUN: begin
          idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
          rp_q  <= (rp_q == '0) ? LastIdx : rp_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      rnd_q <= biased[ACC_W:FRAC_W];
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      saturated_q <= sat_hi || sat_lo;
      if (sat_hi) begin
        filtered_q <= SAT_MAX;
      end else if (sat_lo) begin
        filtered_q <= SAT_MIN;
      end else begin
        filtered_q <= rnd_q[SAMPLE_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = saturated_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastIdx)
    else $error("write position out of range");

  a_filter_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_filter) |=> (state_q == S_RUN))
    else $error("filter word did not start a MAC pass");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (filtered_o == SAT_MAX || filtered_o == SAT_MIN))
    else $error("saturated word not at a rail");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(filtered_q) && $stable(saturated_q))
    else $error("pending output word overwritten");

endmodule
